/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. Each one collapses to nothing when
// ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPL(lbl, c, rn, ante, cons, msg) \
	lbl: assert property (@(posedge c) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// The condition must never hold at a clock edge.
`define ASSERT_NEVER(lbl, c, rn, cond, msg) \
	lbl: assert property (@(posedge c) disable iff (!(rn)) !(cond)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, c, rn, ante, cons, msg)
`define ASSERT_NEVER(lbl, c, rn, cond, msg)

`endif

`endif

/* rtl/core/srchk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srchk_pkg;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_HEADER = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_ABORT  = 2'd3
	} action_t;

	localparam logic [3:0] MT_PING     = 4'd1;
	localparam logic [3:0] MT_PONG     = 4'd2;
	localparam logic [3:0] MT_FILEHEAD = 4'd3;
	localparam logic [3:0] MT_FILEBODY = 4'd4;
	localparam logic [3:0] MT_CMDTINY  = 4'd5;
	localparam logic [3:0] MT_CMDLONG  = 4'd6;
	localparam logic [3:0] MT_TEXTTINY = 4'd7;
	localparam logic [3:0] MT_TEXTLONG = 4'd8;

	localparam logic [1:0] KIND_CMD  = 2'd0;
	localparam logic [1:0] KIND_FILE = 2'd1;
	localparam logic [1:0] KIND_TEXT = 2'd2;

	localparam logic [1:0] REG_KIND     = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [1:0]  KIND_RESET     = KIND_CMD;
	localparam logic [31:0] CAPACITY_RESET = 32'hFFFF_FFFF;
	localparam logic [7:0]  TIMEOUT_RESET  = 8'd20;

	localparam logic [2:0] ST_STOPPED = 3'd0;
	localparam logic [2:0] ST_WAITING = 3'd1;
	localparam logic [2:0] ST_WORKING = 3'd2;
	localparam logic [2:0] ST_OK      = 3'd3;
	localparam logic [2:0] ST_ABORTED = 3'd4;
	localparam logic [2:0] ST_LOST    = 3'd5;
	localparam logic [2:0] ST_TIMEOUT = 3'd6;

	// Item class as seen by the back end. Tiny and long are the message
	// types that pass the command or text filter.
	typedef enum logic [3:0] {
		CLS_NONE  = 4'd0,
		CLS_START = 4'd1,
		CLS_ABORT = 4'd2,
		CLS_TICK  = 4'd3,
		CLS_PING  = 4'd4,
		CLS_PONG  = 4'd5,
		CLS_TINY  = 4'd6,
		CLS_LONG  = 4'd7,
		CLS_FHEAD = 4'd8,
		CLS_FBODY = 4'd9
	} cls_t;

	typedef enum logic [6:0] {
		PH_STOPPED = 7'b0000001,
		PH_WAITING = 7'b0000010,
		PH_WORKING = 7'b0000100,
		PH_OK      = 7'b0001000,
		PH_ABORTED = 7'b0010000,
		PH_LOST    = 7'b0100000,
		PH_TIMEOUT = 7'b1000000
	} phase_t;

	typedef struct packed {
		cls_t        cls;
		logic        first_ok;
		logic [47:0] src_mac;
		logic        done_flag;
		logic [7:0]  payload_size;
		logic [15:0] seq_handle;
		logic [31:0] total_bytes;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        accept_payload;
		logic [31:0] write_offset;
		logic        reply_pong;
		logic        record_peer;
		logic [31:0] byte_count;
	} result_t;

	function automatic logic [2:0] phase_status(phase_t ph);
		logic [2:0] st;
		unique case (ph)
			PH_STOPPED: st = ST_STOPPED;
			PH_WAITING: st = ST_WAITING;
			PH_WORKING: st = ST_WORKING;
			PH_OK:      st = ST_OK;
			PH_ABORTED: st = ST_ABORTED;
			PH_LOST:    st = ST_LOST;
			PH_TIMEOUT: st = ST_TIMEOUT;
			default:    st = ST_STOPPED;
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sequence_receive_checker_top.sv */
// An item accepted by the front end is written into the queue, and its result is
// loaded into the response register once the back end takes it from the queue,
// which the back end does only when the response side is not stalled.
// Throughput: one item per cycle while the response side is not stalled.
// Reset: arst_n clears the phase to stopped, the transfer state to zero and
// the registers to their defaults; no item is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sequence_receive_checker_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,

	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  action,
	input  wire logic [47:0] src_mac,
	input  wire logic [3:0]  msg_type,
	input  wire logic        done_flag,
	input  wire logic [7:0]  payload_size,
	input  wire logic [15:0] seq_handle,
	input  wire logic [31:0] total_bytes,
	input  wire logic [31:0] bytes_sent,

	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [2:0]       status,
	output logic             accept_payload,
	output logic [31:0]      write_offset,
	output logic             reply_pong,
	output logic             record_peer,
	output logic [31:0]      byte_count
);

	logic [1:0]         kind_q;
	logic [31:0]        capacity_q;
	logic [7:0]         limit_q;
	logic               cfg_write;
	logic [1:0]         reg_idx;

	logic               push_valid;
	logic               push_ready;
	srchk_pkg::item_t   push_item;
	logic               pop_valid;
	logic               pop_ready;
	srchk_pkg::item_t   pop_item;
	srchk_pkg::result_t rsp;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= srchk_pkg::KIND_RESET;
			capacity_q <= srchk_pkg::CAPACITY_RESET;
			limit_q    <= srchk_pkg::TIMEOUT_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				srchk_pkg::REG_KIND:     kind_q     <= pwdata[1:0];
				srchk_pkg::REG_CAPACITY: capacity_q <= pwdata;
				srchk_pkg::REG_TIMEOUT:  limit_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			srchk_pkg::REG_KIND:     prdata = {30'd0, kind_q};
			srchk_pkg::REG_CAPACITY: prdata = capacity_q;
			srchk_pkg::REG_TIMEOUT:  prdata = {24'd0, limit_q};
			default:                 prdata = '0;
		endcase
	end

	srchk_front u_front (
		.transfer_kind   (kind_q),
		.buffer_capacity (capacity_q),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.action          (action),
		.src_mac         (src_mac),
		.msg_type        (msg_type),
		.done_flag       (done_flag),
		.payload_size    (payload_size),
		.seq_handle      (seq_handle),
		.total_bytes     (total_bytes),
		.bytes_sent      (bytes_sent),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_item       (push_item)
	);

	srchk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	srchk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_limit (limit_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp)
	);

	assign status         = rsp.status;
	assign accept_payload = rsp.accept_payload;
	assign write_offset   = rsp.write_offset;
	assign reply_pong     = rsp.reply_pong;
	assign record_peer    = rsp.record_peer;
	assign byte_count     = rsp.byte_count;

	// A stored payload and a ping or pong answer never come from the same transaction.
	`ASSERT_NEVER(a_payload_vs_ping, clk, arst_n, rsp_valid && accept_payload && (reply_pong || record_peer), "payload accepted together with ping or pong")
	`ASSERT_IMPL(a_offset_zero, clk, arst_n, rsp_valid && !accept_payload, write_offset == 32'd0, "write offset set without accepted payload")
	`ASSERT_IMPL(a_stopped_empty, clk, arst_n, rsp_valid && (status == srchk_pkg::ST_STOPPED), (byte_count == 32'd0) && !accept_payload, "bytes counted while stopped")
	`ASSERT_IMPL(a_count_covers, clk, arst_n, rsp_valid && accept_payload, byte_count >= write_offset, "byte count behind write offset")

endmodule

`default_nettype wire

/* rtl/core/srchk_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module srchk_front (
	input  wire logic [1:0]        transfer_kind,
	input  wire logic [31:0]       buffer_capacity,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [1:0]        action,
	input  wire logic [47:0]       src_mac,
	input  wire logic [3:0]        msg_type,
	input  wire logic              done_flag,
	input  wire logic [7:0]        payload_size,
	input  wire logic [15:0]       seq_handle,
	input  wire logic [31:0]       total_bytes,
	input  wire logic [31:0]       bytes_sent,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output srchk_pkg::item_t       push_item
);

	srchk_pkg::cls_t hdr_cls;
	srchk_pkg::cls_t cls;
	logic            size_ok;

	// Header filter by transfer kind. The file kind keeps head and body
	// apart, since which of them is wanted depends on the phase.
	always_comb begin
		hdr_cls = srchk_pkg::CLS_NONE;
		if (msg_type == srchk_pkg::MT_PING) begin
			hdr_cls = srchk_pkg::CLS_PING;
		end else if (msg_type == srchk_pkg::MT_PONG) begin
			hdr_cls = srchk_pkg::CLS_PONG;
		end else begin
			unique case (transfer_kind)
				srchk_pkg::KIND_CMD: begin
					if (msg_type == srchk_pkg::MT_CMDTINY)
						hdr_cls = srchk_pkg::CLS_TINY;
					else if (msg_type == srchk_pkg::MT_CMDLONG)
						hdr_cls = srchk_pkg::CLS_LONG;
				end
				srchk_pkg::KIND_FILE: begin
					if (msg_type == srchk_pkg::MT_FILEHEAD)
						hdr_cls = srchk_pkg::CLS_FHEAD;
					else if (msg_type == srchk_pkg::MT_FILEBODY)
						hdr_cls = srchk_pkg::CLS_FBODY;
				end
				srchk_pkg::KIND_TEXT: begin
					if (msg_type == srchk_pkg::MT_TEXTTINY)
						hdr_cls = srchk_pkg::CLS_TINY;
					else if (msg_type == srchk_pkg::MT_TEXTLONG)
						hdr_cls = srchk_pkg::CLS_LONG;
				end
				default: hdr_cls = srchk_pkg::CLS_NONE;
			endcase
		end
	end

	always_comb begin
		unique case (srchk_pkg::action_t'(action))
			srchk_pkg::ACT_START:  cls = srchk_pkg::CLS_START;
			srchk_pkg::ACT_HEADER: cls = hdr_cls;
			srchk_pkg::ACT_TICK:   cls = srchk_pkg::CLS_TICK;
			srchk_pkg::ACT_ABORT:  cls = srchk_pkg::CLS_ABORT;
			default:               cls = srchk_pkg::CLS_NONE;
		endcase
	end

	// A first packet must carry its whole count itself, and outside file
	// mode the announced size must fit the buffer.
	assign size_ok = bytes_sent == {24'd0, payload_size};

	always_comb begin
		push_item.cls          = cls;
		push_item.first_ok     = size_ok && ((transfer_kind == srchk_pkg::KIND_FILE)
			|| (total_bytes <= buffer_capacity));
		push_item.src_mac      = src_mac;
		push_item.done_flag    = done_flag;
		push_item.payload_size = payload_size;
		push_item.seq_handle   = seq_handle;
		push_item.total_bytes  = total_bytes;
	end

	assign push_valid = req_valid;
	assign req_ready  = push_ready;

endmodule

`default_nettype wire

/* rtl/core/srchk_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module srchk_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire srchk_pkg::item_t  push_item,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output srchk_pkg::item_t       pop_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	srchk_pkg::item_t entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/srchk_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module srchk_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        timeout_limit,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire srchk_pkg::item_t  pop_item,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output srchk_pkg::result_t     rsp
);

	srchk_pkg::phase_t  phase_q, phase_d;
	logic [47:0]        peer_q, peer_d;
	logic [15:0]        id_q, id_d;
	logic [31:0]        exp_q, exp_d;
	logic [31:0]        cnt_q, cnt_d;
	logic [7:0]         idle_q, idle_d;
	srchk_pkg::result_t res;
	srchk_pkg::result_t rsp_q;
	logic               rsp_valid_q;

	logic        take_item;
	logic        is_wait;
	logic        is_work;
	logic        first_pkt;
	logic        body_pkt;
	logic        do_take;
	logic [31:0] exp_eff;
	logic [32:0] sum_w;
	logic [31:0] cnt_sum;
	logic        full;
	logic [8:0]  tick_n;
	logic        accept;
	logic        pong;
	logic        peer_rec;

	assign pop_ready = !rsp_valid_q || rsp_ready;
	assign take_item = pop_valid && pop_ready;

	assign is_wait = phase_q == srchk_pkg::PH_WAITING;
	assign is_work = phase_q == srchk_pkg::PH_WORKING;

	assign first_pkt = is_wait && pop_item.first_ok
		&& ((pop_item.cls == srchk_pkg::CLS_LONG) || (pop_item.cls == srchk_pkg::CLS_FHEAD));

	// While working, a tiny type that got through the filter counts as a body packet.
	assign body_pkt = is_work
		&& ((pop_item.cls == srchk_pkg::CLS_TINY) || (pop_item.cls == srchk_pkg::CLS_LONG)
			|| (pop_item.cls == srchk_pkg::CLS_FBODY))
		&& (pop_item.src_mac == peer_q) && (pop_item.seq_handle == id_q);

	assign do_take = first_pkt || body_pkt;
	assign exp_eff = first_pkt ? pop_item.total_bytes : exp_q;
	assign sum_w   = {1'b0, cnt_q} + {25'd0, pop_item.payload_size};
	assign cnt_sum = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
	assign full    = cnt_sum == exp_eff;
	assign tick_n  = {1'b0, idle_q} + 9'd1;

	always_comb begin
		phase_d  = phase_q;
		peer_d   = peer_q;
		id_d     = id_q;
		exp_d    = exp_q;
		cnt_d    = cnt_q;
		idle_d   = idle_q;
		accept   = 1'b0;
		pong     = 1'b0;
		peer_rec = 1'b0;
		unique case (pop_item.cls)
			srchk_pkg::CLS_START: begin
				phase_d = srchk_pkg::PH_WAITING;
				peer_d  = '0;
				id_d    = '0;
				exp_d   = '0;
				cnt_d   = '0;
				idle_d  = '0;
			end
			srchk_pkg::CLS_ABORT: begin
				if (is_wait || is_work)
					phase_d = srchk_pkg::PH_ABORTED;
			end
			srchk_pkg::CLS_TICK: begin
				if (is_work) begin
					if (tick_n > {1'b0, timeout_limit})
						phase_d = srchk_pkg::PH_TIMEOUT;
					idle_d = tick_n[8] ? 8'hFF : tick_n[7:0];
				end
			end
			srchk_pkg::CLS_PING: pong = 1'b1;
			srchk_pkg::CLS_PONG: peer_rec = 1'b1;
			srchk_pkg::CLS_TINY: begin
				// A tiny message in the waiting phase is a complete transfer.
				if (is_wait) begin
					peer_d  = pop_item.src_mac;
					exp_d   = {24'd0, pop_item.payload_size};
					cnt_d   = {24'd0, pop_item.payload_size};
					phase_d = srchk_pkg::PH_OK;
					accept  = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_take) begin
			accept = 1'b1;
			cnt_d  = cnt_sum;
			idle_d = '0;
			if (first_pkt) begin
				peer_d = pop_item.src_mac;
				id_d   = pop_item.seq_handle;
				exp_d  = pop_item.total_bytes;
			end
			if (pop_item.done_flag && full)
				phase_d = srchk_pkg::PH_OK;
			else if (pop_item.done_flag || full)
				phase_d = srchk_pkg::PH_LOST;
			else
				phase_d = srchk_pkg::PH_WORKING;
		end
	end

	always_comb begin
		res.status         = srchk_pkg::phase_status(phase_d);
		res.accept_payload = accept;
		res.write_offset   = do_take ? cnt_q : '0;
		res.reply_pong     = pong;
		res.record_peer    = peer_rec;
		res.byte_count     = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= srchk_pkg::PH_STOPPED;
			peer_q      <= '0;
			id_q        <= '0;
			exp_q       <= '0;
			cnt_q       <= '0;
			idle_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take_item) begin
				phase_q <= phase_d;
				peer_q  <= peer_d;
				id_q    <= id_d;
				exp_q   <= exp_d;
				cnt_q   <= cnt_d;
				idle_q  <= idle_d;
			end
			if (take_item)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* tb/sequence_receive_checker_top_test.sv */
`timescale 1ns / 1ps

module sequence_receive_checker_top_test;

	typedef struct packed {
		srchk_pkg::action_t act;
		logic [47:0] mac;
		logic [3:0]  mt;
		logic        done;
		logic [7:0]  psize;
		logic [15:0] hid;
		logic [31:0] total;
		logic [31:0] sent;
	} hdr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  action = '0;
	logic [47:0] src_mac = '0;
	logic [3:0]  msg_type = '0;
	logic        done_flag = 1'b0;
	logic [7:0]  payload_size = '0;
	logic [15:0] seq_handle = '0;
	logic [31:0] total_bytes = '0;
	logic [31:0] bytes_sent = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [2:0]  status;
	logic        accept_payload;
	logic [31:0] write_offset;
	logic        reply_pong;
	logic        record_peer;
	logic [31:0] byte_count;

	// Mirror of the configuration registers and of the transfer state.
	logic [1:0]  kind_m = srchk_pkg::KIND_RESET;
	logic [31:0] cap_m = srchk_pkg::CAPACITY_RESET;
	logic [7:0]  tmo_m = srchk_pkg::TIMEOUT_RESET;
	logic [2:0]  rx_phase = srchk_pkg::ST_STOPPED;
	logic [47:0] peer_mac = '0;
	logic [15:0] xfer_id = '0;
	logic [31:0] xfer_size = '0;
	logic [31:0] rx_count = '0;
	logic [7:0]  idle_cnt = '0;

	srchk_pkg::result_t rsp_due_q[$];
	int      n_errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      hold_cnt = 0;
	int      outcome_cnt[8];
	logic    tx_calm = 1'b0;
	logic    rx_calm = 1'b0;
	logic [2:0] prev_status = srchk_pkg::ST_STOPPED;

	sequence_receive_checker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.src_mac(src_mac),
		.msg_type(msg_type),
		.done_flag(done_flag),
		.payload_size(payload_size),
		.seq_handle(seq_handle),
		.total_bytes(total_bytes),
		.bytes_sent(bytes_sent),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.accept_payload(accept_payload),
		.write_offset(write_offset),
		.reply_pong(reply_pong),
		.record_peer(record_peer),
		.byte_count(byte_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Works out the result of one accepted transaction and moves the
	// transfer state on.
	function automatic srchk_pkg::result_t rx_track(input hdr_t h);
		srchk_pkg::result_t r;
		logic        pass;
		logic        take;
		logic        full;
		logic [8:0]  ticks;
		logic [32:0] sum;
		r = '0;
		take = 1'b0;
		case (h.act)
			srchk_pkg::ACT_START: begin
				rx_phase = srchk_pkg::ST_WAITING;
				peer_mac = '0;
				xfer_id = '0;
				xfer_size = '0;
				rx_count = '0;
				idle_cnt = '0;
			end
			srchk_pkg::ACT_ABORT: begin
				if (rx_phase == srchk_pkg::ST_WAITING || rx_phase == srchk_pkg::ST_WORKING)
					rx_phase = srchk_pkg::ST_ABORTED;
			end
			srchk_pkg::ACT_TICK: begin
				if (rx_phase == srchk_pkg::ST_WORKING) begin
					ticks = {1'b0, idle_cnt} + 9'd1;
					if (ticks > {1'b0, tmo_m})
						rx_phase = srchk_pkg::ST_TIMEOUT;
					idle_cnt = ticks[8] ? 8'hFF : ticks[7:0];
				end
			end
			srchk_pkg::ACT_HEADER: begin
				case (kind_m)
					srchk_pkg::KIND_CMD:
						pass = (h.mt == srchk_pkg::MT_CMDTINY || h.mt == srchk_pkg::MT_CMDLONG);
					srchk_pkg::KIND_FILE:
						pass = (rx_phase == srchk_pkg::ST_WAITING)
							? (h.mt == srchk_pkg::MT_FILEHEAD)
							: (h.mt == srchk_pkg::MT_FILEBODY);
					srchk_pkg::KIND_TEXT:
						pass = (h.mt == srchk_pkg::MT_TEXTTINY || h.mt == srchk_pkg::MT_TEXTLONG);
					default:   pass = 1'b0;
				endcase
				if (h.mt == srchk_pkg::MT_PING) begin
					r.reply_pong = 1'b1;
				end else if (h.mt == srchk_pkg::MT_PONG) begin
					r.record_peer = 1'b1;
				end else if ((rx_phase == srchk_pkg::ST_WAITING
				              || rx_phase == srchk_pkg::ST_WORKING) && pass) begin
					if (rx_phase == srchk_pkg::ST_WAITING) begin
						if (h.mt == srchk_pkg::MT_CMDTINY || h.mt == srchk_pkg::MT_TEXTTINY) begin
							peer_mac = h.mac;
							xfer_size = {24'd0, h.psize};
							rx_count = {24'd0, h.psize};
							rx_phase = srchk_pkg::ST_OK;
							r.accept_payload = 1'b1;
						end else if (h.sent == {24'd0, h.psize} &&
						             (kind_m == srchk_pkg::KIND_FILE || h.total <= cap_m)) begin
							peer_mac = h.mac;
							xfer_id = h.hid;
							xfer_size = h.total;
							rx_phase = srchk_pkg::ST_WORKING;
							take = 1'b1;
						end
					end else begin
						take = (h.mac == peer_mac && h.hid == xfer_id);
					end
					if (take) begin
						r.accept_payload = 1'b1;
						r.write_offset = rx_count;
						sum = {1'b0, rx_count} + {25'd0, h.psize};
						rx_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						idle_cnt = '0;
						full = (rx_count == xfer_size);
						if (h.done && full)
							rx_phase = srchk_pkg::ST_OK;
						else if (h.done || full)
							rx_phase = srchk_pkg::ST_LOST;
					end
				end
			end
		endcase
		r.status = rx_phase;
		r.byte_count = rx_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : rsp_monitor
		srchk_pkg::result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due_q.size() == 0) begin
				$display("%0t: result with no transaction outstanding, status %0d",
				         $time, status);
				n_errors++;
			end else begin
				want = rsp_due_q.pop_front();
				check_field("status", {29'd0, want.status}, {29'd0, status});
				check_field("accept_payload", {31'd0, want.accept_payload},
				            {31'd0, accept_payload});
				check_field("write_offset", want.write_offset, write_offset);
				check_field("reply_pong", {31'd0, want.reply_pong}, {31'd0, reply_pong});
				check_field("record_peer", {31'd0, want.record_peer}, {31'd0, record_peer});
				check_field("byte_count", want.byte_count, byte_count);
				if (want.status != prev_status)
					outcome_cnt[want.status]++;
				prev_status = want.status;
				n_checked++;
			end
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= rx_calm || ($urandom_range(99) >= 21);
		end
	end

	function automatic logic [47:0] rnd48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic hdr_t mk(input srchk_pkg::action_t a, input logic [3:0] mt,
	                            input logic [47:0] mac,
	                            input logic [15:0] hid, input logic [7:0] ps,
	                            input logic [31:0] tot, input logic [31:0] snt, input logic dn);
		hdr_t h;
		h.act = a;
		h.mt = mt;
		h.mac = mac;
		h.hid = hid;
		h.psize = ps;
		h.total = tot;
		h.sent = snt;
		h.done = dn;
		return h;
	endfunction

	function automatic hdr_t noise_item();
		logic [3:0]  mt;
		logic [15:0] hid;
		logic [7:0]  ps;
		logic        dn;
		mt = 4'($urandom_range(15));
		hid = 16'($urandom);
		ps = 8'($urandom_range(250));
		dn = 1'($urandom_range(1));
		return mk(srchk_pkg::action_t'($urandom_range(3)), mt, rnd48(), hid, ps, $urandom,
		          $urandom, dn);
	endfunction

	function automatic hdr_t ctl(input srchk_pkg::action_t a);
		hdr_t h;
		h = noise_item();
		h.act = a;
		return h;
	endfunction

	task automatic send_item(input hdr_t h);
		while (!tx_calm && $urandom_range(99) < 21) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= h.act;
		src_mac <= h.mac;
		msg_type <= h.mt;
		done_flag <= h.done;
		payload_size <= h.psize;
		seq_handle <= h.hid;
		total_bytes <= h.total;
		bytes_sent <= h.sent;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		rsp_due_q.insert(rsp_due_q.size(), rx_track(h));
		n_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			srchk_pkg::REG_KIND:     kind_m = val[1:0];
			srchk_pkg::REG_CAPACITY: cap_m = val;
			srchk_pkg::REG_TIMEOUT:  tmo_m = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [1:0] kind, input logic [31:0] cap,
	                         input logic [7:0] tmo);
		drain();
		reg_write(srchk_pkg::REG_KIND, {30'd0, kind});
		reg_write(srchk_pkg::REG_CAPACITY, cap);
		reg_write(srchk_pkg::REG_TIMEOUT, {24'd0, tmo});
	endtask

	// One transfer in the shape a real sender produces, with random content
	// and now and then a corrupted field or an interleaved transaction.
	task automatic random_transfer();
		logic [47:0] mac;
		logic [15:0] hid;
		logic [3:0]  t_tiny;
		logic [3:0]  t_first;
		logic [3:0]  t_body;
		logic [7:0]  ps;
		logic [31:0] tot;
		logic [31:0] cum;
		logic [7:0]  sz[6];
		int          npk;
		int          roll;
		hdr_t        h;
		mac = rnd48();
		hid = 16'($urandom);
		case (kind_m)
			srchk_pkg::KIND_CMD: begin
				t_tiny = srchk_pkg::MT_CMDTINY;
				t_first = srchk_pkg::MT_CMDLONG;
				t_body = srchk_pkg::MT_CMDLONG;
			end
			srchk_pkg::KIND_FILE: begin
				t_tiny = srchk_pkg::MT_FILEBODY;
				t_first = srchk_pkg::MT_FILEHEAD;
				t_body = srchk_pkg::MT_FILEBODY;
			end
			srchk_pkg::KIND_TEXT: begin
				t_tiny = srchk_pkg::MT_TEXTTINY;
				t_first = srchk_pkg::MT_TEXTLONG;
				t_body = srchk_pkg::MT_TEXTLONG;
			end
			default: begin
				t_tiny = 4'($urandom_range(3, 8));
				t_first = 4'($urandom_range(3, 8));
				t_body = 4'($urandom_range(3, 8));
			end
		endcase
		send_item(ctl(srchk_pkg::ACT_START));
		if ($urandom_range(99) < 15) begin
			ps = 8'($urandom_range(250));
			send_item(mk(srchk_pkg::ACT_HEADER, t_tiny, mac, hid, ps, $urandom, $urandom,
			             1'($urandom_range(1))));
		end else begin
			npk = $urandom_range(1, 6);
			tot = '0;
			for (int i = 0; i < npk; i++) begin
				sz[i] = 8'($urandom_range(250));
				if ($urandom_range(9) == 0)
					sz[i] = '0;
				tot += {24'd0, sz[i]};
			end
			roll = $urandom_range(99);
			if (roll < 10)
				tot += $urandom_range(1, 300);
			else if (roll < 15)
				tot = $urandom;
			cum = '0;
			for (int i = 0; i < npk; i++) begin
				roll = $urandom_range(99);
				if (roll < 6) begin
					repeat ($urandom_range(1, 4)) send_item(ctl(srchk_pkg::ACT_TICK));
				end else if (roll < 9) begin
					h = ctl(srchk_pkg::ACT_HEADER);
					h.mt = $urandom_range(1) ? srchk_pkg::MT_PING : srchk_pkg::MT_PONG;
					send_item(h);
				end else if (roll < 12) begin
					h = mk(srchk_pkg::ACT_HEADER, t_body, mac, hid, sz[i], tot, cum, 1'b0);
					if ($urandom_range(1))
						h.mac[$urandom_range(47)] ^= 1'b1;
					else
						h.hid[$urandom_range(15)] ^= 1'b1;
					send_item(h);
				end else if (roll < 14) begin
					send_item(ctl(srchk_pkg::ACT_ABORT));
				end else if (roll < 16) begin
					send_item(noise_item());
				end
				cum += {24'd0, sz[i]};
				h = mk(srchk_pkg::ACT_HEADER, (i == 0) ? t_first : t_body, mac, hid, sz[i],
				       tot, cum, i == npk - 1);
				// A tiny type that passes the filter counts as a body packet.
				if (i > 0 && kind_m != srchk_pkg::KIND_FILE && $urandom_range(9) == 0)
					h.mt = t_tiny;
				if (i == 0 && $urandom_range(99) < 6)
					h.sent = cum + 32'd1;
				if ($urandom_range(99) < 5)
					h.done = ~h.done;
				send_item(h);
			end
		end
		if ($urandom_range(99) < 10)
			send_item(mk(srchk_pkg::ACT_HEADER, t_body, mac, hid, 8'd1, 32'd1, 32'd1, 1'b1));
	endtask

	task automatic run_phase(input logic [1:0] kind, input logic [31:0] cap,
	                         input logic [7:0] tmo, input int n);
		int stop_at;
		configure(kind, cap, tmo);
		stop_at = n_sent + n;
		while (n_sent < stop_at) begin
			if ($urandom_range(99) < 10)
				send_item(noise_item());
			else
				random_transfer();
		end
	endtask

	task automatic test_directed();
		logic [47:0] m;
		m = 48'hFFFF_FFFF_FFFF;
		// Everything before the first start only answers pings and pongs.
		send_item(ctl(srchk_pkg::ACT_TICK));
		send_item(ctl(srchk_pkg::ACT_ABORT));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, m, 16'hFFFF, 8'd10,
		             32'd10, 32'd10, 1'b1));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_PING, m, 16'd0, 8'd0, 32'd0,
		             32'd0, 1'b0));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, 4'd0, m, 16'd0, 8'd5, 32'd5, 32'd5, 1'b1));
		send_item(mk(srchk_pkg::ACT_HEADER, 4'hF, m, 16'd0, 8'd5, 32'd5, 32'd5, 1'b1));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_FILEHEAD, m, 16'd0, 8'd5, 32'd5,
		             32'd5, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDTINY, m, 16'hFFFF, 8'd250, '1,
		             '1, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDTINY, m, 16'd0, 8'd7, 32'd0,
		             32'd0, 1'b1));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_PONG, 48'd0, 16'd0, 8'd0, 32'd0,
		             32'd0, 1'b0));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, m, 16'hFFFF, 8'd10, '1,
		             32'd11, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, m, 16'hFFFF, 8'd0, '1,
		             32'd0, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, {m[47:1], 1'b0}, 16'hFFFF,
		             8'd50, '1, 32'd50, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, m, 16'h7FFF, 8'd50, '1,
		             32'd50, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_PING, m, 16'd0, 8'd0, 32'd0,
		             32'd0, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDTINY, m, 16'hFFFF, 8'd250, '1,
		             32'd250, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, m, 16'hFFFF, 8'd1, '1,
		             32'd251, 1'b1));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(ctl(srchk_pkg::ACT_ABORT));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'd0, 16'd0, 8'd10,
		             32'd10, 32'd10, 1'b0));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h1234, 16'd1, 8'd10,
		             32'd20, 32'd10, 1'b0));
		send_item(ctl(srchk_pkg::ACT_TICK));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h1234, 16'd1, 8'd10,
		             32'd20, 32'd20, 1'b1));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h1234, 16'd1, 8'd10,
		             32'd90, 32'd10, 1'b0));
		send_item(ctl(srchk_pkg::ACT_ABORT));
	endtask

	task automatic test_capacity();
		configure(srchk_pkg::KIND_TEXT, 32'd100, srchk_pkg::TIMEOUT_RESET);
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_TEXTLONG, 48'h5, 16'd9, 8'd50,
		             32'd100, 32'd50, 1'b0));
		send_item(ctl(srchk_pkg::ACT_ABORT));
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_TEXTLONG, 48'h5, 16'd9, 8'd50,
		             32'd101, 32'd50, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_TEXTTINY, 48'h5, 16'd9, 8'd250,
		             32'd0, 32'd0, 1'b0));
		// File transfers ignore the capacity limit.
		configure(srchk_pkg::KIND_FILE, 32'd0, srchk_pkg::TIMEOUT_RESET);
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h7, 16'd3, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_FILEBODY, 48'h7, 16'd3, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_FILEHEAD, 48'h7, 16'd3, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_FILEHEAD, 48'h7, 16'd3, 8'd10,
		             32'd1000, 32'd20, 1'b0));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_FILEBODY, 48'h7, 16'd3, 8'd10,
		             32'd1000, 32'd20, 1'b1));
		// With the unused kind code no file, command or text message type gets through.
		configure(2'd3, 32'hFFFF_FFFF, srchk_pkg::TIMEOUT_RESET);
		send_item(ctl(srchk_pkg::ACT_START));
		for (int t = srchk_pkg::MT_FILEHEAD; t <= srchk_pkg::MT_TEXTLONG; t++)
			send_item(mk(srchk_pkg::ACT_HEADER, 4'(t), 48'h7, 16'd3, 8'd4, 32'd4, 32'd4,
			             1'b1));
	endtask

	task automatic test_idle_timeout();
		configure(srchk_pkg::KIND_CMD, 32'hFFFF_FFFF, 8'd0);
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h9, 16'd2, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		send_item(ctl(srchk_pkg::ACT_TICK));
		send_item(ctl(srchk_pkg::ACT_ABORT));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h9, 16'd2, 8'd10,
		             32'd1000, 32'd20, 1'b0));
		configure(srchk_pkg::KIND_CMD, 32'hFFFF_FFFF, 8'd1);
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h9, 16'd2, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		send_item(ctl(srchk_pkg::ACT_TICK));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h9, 16'd2, 8'd10,
		             32'd1000, 32'd20, 1'b0));
		send_item(ctl(srchk_pkg::ACT_TICK));
		send_item(ctl(srchk_pkg::ACT_TICK));
		configure(srchk_pkg::KIND_CMD, 32'hFFFF_FFFF, 8'd255);
		send_item(ctl(srchk_pkg::ACT_START));
		send_item(mk(srchk_pkg::ACT_HEADER, srchk_pkg::MT_CMDLONG, 48'h9, 16'd2, 8'd10,
		             32'd1000, 32'd10, 1'b0));
		repeat (257) send_item(ctl(srchk_pkg::ACT_TICK));
	endtask

	task automatic test_random_phases();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_phase(srchk_pkg::KIND_CMD, 32'hFFFF_FFFF, 8'd20, 150);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		run_phase(srchk_pkg::KIND_FILE, 32'd0, 8'd1, 150);
		run_phase(srchk_pkg::KIND_TEXT, 32'd600, 8'd3, 150);
		run_phase(srchk_pkg::KIND_CMD, 32'd0, 8'd255, 150);
		run_phase(2'd3, $urandom, 8'd0, 150);
		run_phase(srchk_pkg::KIND_TEXT, 32'hFFFF_FFFF, 8'd5, 150);
		run_phase(srchk_pkg::KIND_FILE, $urandom, 8'd2, 150);
	endtask

	// The receiver holds off while the sender keeps offering, so the block
	// fills up and stalls its input.
	task automatic test_backpressure();
		int stop_at;
		configure(srchk_pkg::KIND_CMD, 32'd2000, 8'd4);
		tx_calm = 1'b1;
		hold_cnt = 120;
		stop_at = n_sent + 40;
		while (n_sent < stop_at)
			random_transfer();
		tx_calm = 1'b0;
	endtask

	task automatic test_drain_pause();
		random_transfer();
		drain();
		random_transfer();
		drain();
		random_transfer();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_idle_timeout();
		test_random_phases();
		test_backpressure();
		test_drain_pause();
		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d transactions and checked %0d results over all transfer kinds,",
		         n_sent, n_checked);
		$display("capacity and idle limits; ok %0d, aborted %0d, lost %0d, timeout %0d.",
		         outcome_cnt[srchk_pkg::ST_OK], outcome_cnt[srchk_pkg::ST_ABORTED],
		         outcome_cnt[srchk_pkg::ST_LOST], outcome_cnt[srchk_pkg::ST_TIMEOUT]);
		if (n_errors == 0 && rsp_due_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/srchk_pkg.sv
rtl/core/srchk_front.sv
rtl/core/srchk_queue.sv
rtl/core/srchk_back.sv
rtl/core/sequence_receive_checker_top.sv
tb/sequence_receive_checker_top_test.sv
